>>> design/point_in_polygon_test_core_defines.svh
// Assertion macros for the point-in-polygon test core.
// Depends on nothing; users supply clk and arst_n in scope.
`ifndef POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PIPT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/pipt_pkg.sv
// Shared types and constants of the point-in-polygon test core.
// No dependencies.
package pipt_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int COORD_W      = 16;
	localparam int IDX_W        = 4;
	localparam int CNT_W        = 5;
	localparam int VIDX_W       = $clog2(MAX_VERTICES);
	localparam int NV_W         = $clog2(MAX_VERTICES + 1);
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int LATENCY      = 5;

	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(3);

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TEST = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} point_t;

endpackage

>>> design/pipt_edge_cell.sv
// One polygon edge: crossing test of a point against segment v1 -> v2.
// Three register stages: compares/differences, products, final compare.
// Depends on pipt_pkg.
module pipt_edge_cell import pipt_pkg::*; (
	input  logic   clk,
	input  point_t pt,
	input  point_t v1,
	input  point_t v2,
	input  logic   en,
	output logic   hit_s4
);

	coord_t px, py, x1, y1, x2, y2;
	coord_t ylo, yhi, xhi;

	logic  cond_s2, vert_s2, dypos_s2;
	diff_t dxp_s2, dy_s2, dyp_s2, dx_s2;

	logic  cond_s3, vert_s3, dypos_s3;
	prod_t lhs_s3, rhs_s3;

	logic  cross_ok;

	assign px = pt.x;
	assign py = pt.y;
	assign x1 = v1.x;
	assign y1 = v1.y;
	assign x2 = v2.x;
	assign y2 = v2.y;

	assign ylo = (y1 < y2) ? y1 : y2;
	assign yhi = (y1 > y2) ? y1 : y2;
	assign xhi = (x1 > x2) ? x1 : x2;

	always_ff @(posedge clk) begin
		cond_s2  <= en && (py > ylo) && (py <= yhi) && (px <= xhi) && (y1 != y2);
		vert_s2  <= (x1 == x2);
		dypos_s2 <= (y2 > y1);
		dxp_s2   <= diff_t'(px) - diff_t'(x1);
		dy_s2    <= diff_t'(y2) - diff_t'(y1);
		dyp_s2   <= diff_t'(py) - diff_t'(y1);
		dx_s2    <= diff_t'(x2) - diff_t'(x1);
	end

	always_ff @(posedge clk) begin
		cond_s3  <= cond_s2;
		vert_s3  <= vert_s2;
		dypos_s3 <= dypos_s2;
		lhs_s3   <= prod_t'(dxp_s2) * prod_t'(dy_s2);
		rhs_s3   <= prod_t'(dyp_s2) * prod_t'(dx_s2);
	end

	// sense of the compare flips with the edge direction
	assign cross_ok = dypos_s3 ? (lhs_s3 <= rhs_s3) : (lhs_s3 >= rhs_s3);

	always_ff @(posedge clk) begin
		hit_s4 <= cond_s3 && (vert_s3 || cross_ok);
	end

endmodule

>>> design/pipt_parity.sv
// Parity of the per-edge crossing flags and the result strobe.
// Depends on pipt_pkg.
module pipt_parity import pipt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_s4,
	input  logic [MAX_VERTICES-1:0] hit_s4,
	output logic                    done,
	output logic                    inside_res
);

	logic valid_s5;
	logic par_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		par_s5 <= ^hit_s4;
	end

	assign done       = valid_s5;
	assign inside_res = par_s5;

endmodule

>>> design/point_in_polygon_test_core.sv
// Point-in-polygon test core: vertex store, one crossing cell per edge, parity.
// Depends on pipt_pkg, pipt_edge_cell, pipt_parity and the defines header.
//
// A beat is taken whenever start is high; busy is always low, so one beat can
// enter every clock. A load beat writes its vertex at the accepting edge and
// gives no result. A test beat gives one result: done is high for one cycle,
// with inside_res valid in that cycle. The test point passes the input
// register, the three stages of each edge cell (compares, 17x17 products,
// product compare) and the parity register. Results come in test order and
// cannot be held off. A test sees every load accepted before it.
// vertex_count is written with cfg_we/cfg_data; the user must write it only
// while no test is in flight, as the block does not enforce it. Counts above
// 16 act as 16.
`include "point_in_polygon_test_core_defines.svh"

module point_in_polygon_test_core import pipt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                action,
	input  logic [IDX_W-1:0]    vertex_index,
	input  coord_t              coord_x,
	input  coord_t              coord_y,
	output logic                done,
	output logic                inside_res,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_data
);

	logic [CNT_W-1:0]  vcount_q;
	logic [NV_W-1:0]   n_sat;
	logic              accept;
	logic              load_ok;
	logic [VIDX_W-1:0] ld_slot;

	coord_t vx_q [MAX_VERTICES];
	coord_t vy_q [MAX_VERTICES];

	logic   valid_s1, valid_s2, valid_s3, valid_s4;
	point_t pt_s1;

	logic [MAX_VERTICES-1:0] en;
	logic [MAX_VERTICES-1:0] hit_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CNT_RESET;
		end else if (cfg_we) begin
			vcount_q <= cfg_data;
		end
	end

	assign n_sat = (32'(vcount_q) > MAX_VERTICES) ? NV_W'(MAX_VERTICES) : NV_W'(vcount_q);

	// vertex store
	assign load_ok = accept && (action == ACT_LOAD) && (32'(vertex_index) < MAX_VERTICES);
	assign ld_slot = VIDX_W'(vertex_index);

	always_ff @(posedge clk) begin
		if (load_ok) begin
			vx_q[ld_slot] <= coord_x;
			vy_q[ld_slot] <= coord_y;
		end
	end

	// test pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept && (action == ACT_TEST);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (action == ACT_TEST)) begin
			pt_s1.x <= coord_x;
			pt_s1.y <= coord_y;
		end
	end

	// edge g+1 runs from vertex g to vertex g+1, or back to vertex 0 when last
	for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_edge
		point_t v1, v2;

		assign en[g] = (NV_W'(g + 1) <= n_sat);
		assign v1.x  = vx_q[g];
		assign v1.y  = vy_q[g];

		if (g + 1 < MAX_VERTICES) begin : g_mid
			assign v2.x = (n_sat == NV_W'(g + 1)) ? vx_q[0] : vx_q[g + 1];
			assign v2.y = (n_sat == NV_W'(g + 1)) ? vy_q[0] : vy_q[g + 1];
		end else begin : g_last
			assign v2.x = vx_q[0];
			assign v2.y = vy_q[0];
		end

		pipt_edge_cell u_cell (
			.clk    (clk),
			.pt     (pt_s1),
			.v1     (v1),
			.v2     (v2),
			.en     (en[g]),
			.hit_s4 (hit_s4[g])
		);
	end

	pipt_parity u_parity (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s4   (valid_s4),
		.hit_s4     (hit_s4),
		.done       (done),
		.inside_res (inside_res)
	);

	`PIPT_ASSERT_NOW(a_done_latency, done, $past(accept && (action == ACT_TEST), LATENCY), "result without a test beat five cycles earlier")
	`PIPT_ASSERT_NEXT(a_load_x, load_ok, vx_q[$past(ld_slot)] == $past(coord_x), "vertex x not stored")
	`PIPT_ASSERT_NEXT(a_load_y, load_ok, vy_q[$past(ld_slot)] == $past(coord_y), "vertex y not stored")

endmodule

>>> tb/point_in_polygon_test_core_checker.sv
// Checker for the point-in-polygon test core: tracks vertex loads and the count
// register, predicts the inside flag of each test beat and compares every result.
// Depends on pipt_pkg.
module point_in_polygon_test_core_checker import pipt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             action,
	input  logic [IDX_W-1:0] vertex_index,
	input  coord_t           coord_x,
	input  coord_t           coord_y,
	input  logic             done,
	input  logic             inside_res,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	coord_t           vtx_x [MAX_VERTICES];
	coord_t           vtx_y [MAX_VERTICES];
	logic [CNT_W-1:0] poly_count = CNT_RESET;
	bit               inside_q [$];
	int               errs = 0;
	int               waiting = 0;

	assign fail_count = errs;
	assign pending    = waiting;

	// exact crossing test of one edge, products widened to 64 bits
	function automatic bit edge_crosses(coord_t px, coord_t py,
			coord_t x1, coord_t y1, coord_t x2, coord_t y2);
		longint ylo, yhi, xhi, dy, lhs, rhs;
		ylo = (y1 < y2) ? y1 : y2;
		yhi = (y1 > y2) ? y1 : y2;
		xhi = (x1 > x2) ? x1 : x2;
		if (py <= ylo || py > yhi || px > xhi || y1 == y2)
			return 1'b0;
		if (x1 == x2)
			return 1'b1;
		dy  = longint'(y2) - longint'(y1);
		lhs = (longint'(px) - longint'(x1)) * dy;
		rhs = (longint'(py) - longint'(y1)) * (longint'(x2) - longint'(x1));
		return (dy > 0) ? (lhs <= rhs) : (lhs >= rhs);
	endfunction

	function automatic bit inside_parity(coord_t px, coord_t py);
		int edges;
		int cur;
		bit par;
		edges = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
		par = 1'b0;
		for (int i = 1; i <= edges; i++) begin
			cur = (i == edges) ? 0 : i;
			par ^= edge_crosses(px, py, vtx_x[i-1], vtx_y[i-1], vtx_x[cur], vtx_y[cur]);
		end
		return par;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			poly_count = CNT_RESET;
			inside_q.delete();
			waiting = 0;
		end else begin
			if (done === 1'b1) begin
				if (inside_q.size() == 0) begin
					$error("inside_res: expected none, actual %0d", inside_res);
					errs++;
				end else begin
					want = inside_q.pop_front();
					if (inside_res !== want) begin
						$error("inside_res: expected %0d, actual %0d", want, inside_res);
						errs++;
					end
				end
			end
			if (cfg_we)
				poly_count = cfg_data;
			if (start && !busy) begin
				if (action == ACT_LOAD) begin
					if (vertex_index < MAX_VERTICES) begin
						vtx_x[vertex_index] = coord_x;
						vtx_y[vertex_index] = coord_y;
					end
				end else begin
					inside_q.push_back(inside_parity(coord_x, coord_y));
				end
			end
			waiting = inside_q.size();
		end
	end

endmodule

>>> tb/point_in_polygon_test_core_tb.sv
// Testbench top for the point-in-polygon test core: clock, reset, vertex loads,
// test points and count settings; verdict from point_in_polygon_test_core_checker.
// Depends on pipt_pkg, point_in_polygon_test_core and the checker.
module point_in_polygon_test_core_tb;
	import pipt_pkg::*;

	typedef enum int {SHAPE_WIDE, SHAPE_TINY, SHAPE_GRID, SHAPE_RAIL} shape_e;

	localparam int NUM_PHASES      = 12;
	localparam int BEATS_PER_PHASE = 100;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             action = ACT_LOAD;
	logic [IDX_W-1:0] vertex_index = '0;
	coord_t           coord_x = '0;
	coord_t           coord_y = '0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_data = '0;
	logic             busy;
	logic             done;
	logic             inside_res;
	int               fails;
	int               pending;

	int     vx [MAX_VERTICES];
	int     vy [MAX_VERTICES];
	int     live_n = 3;
	int     beats = 0;
	shape_e shape = SHAPE_WIDE;
	int     phase_counts [NUM_PHASES] = '{4, 1, 16, 0, 31, 5, 2, 9, 16, 12, 6, 3};

	point_in_polygon_test_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.done         (done),
		.inside_res   (inside_res),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	point_in_polygon_test_core_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.vertex_index (vertex_index),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.done         (done),
		.inside_res   (inside_res),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.fail_count   (fails),
		.pending      (pending)
	);

	initial forever #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("point_in_polygon_test_core: mismatch");
		$finish;
	end

	function automatic int clip16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rail_coord();
		case ($urandom_range(3))
			0: return -32768;
			1: return 32767;
			2: return 0;
			default: return int'($urandom_range(65535)) - 32768;
		endcase
	endfunction

	function automatic int pick_coord(int prev);
		case (shape)
			SHAPE_WIDE: return int'($urandom_range(65535)) - 32768;
			SHAPE_TINY: return int'($urandom_range(12)) - 6;
			SHAPE_GRID: begin
				if ($urandom_range(1))
					return prev;
				return int'($urandom_range(2000)) - 1000;
			end
			default: return rail_coord();
		endcase
	endfunction

	task automatic send_beat(input logic act, input int slot, input int x, input int y);
		int gap;
		gap = (beats < 400) ? 37 : (beats < 800) ? 70 : 0;
		while (int'($urandom_range(99)) < gap) begin
			start = 1'b0;
			action = 1'($urandom_range(1));
			vertex_index = IDX_W'($urandom);
			coord_x = coord_t'($urandom);
			coord_y = coord_t'($urandom);
			@(negedge clk);
		end
		start = 1'b1;
		action = act;
		vertex_index = IDX_W'(slot);
		coord_x = coord_t'(x);
		coord_y = coord_t'(y);
		if (act == ACT_LOAD) begin
			vx[slot] = x;
			vy[slot] = y;
		end
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		beats++;
	endtask

	// polygon reload as one run of load beats into slots 0..nv-1
	task automatic load_polygon(input int nv);
		int lx, ly;
		lx = 0;
		ly = 0;
		shape = shape_e'($urandom_range(3));
		for (int i = 0; i < nv; i++) begin
			lx = pick_coord(lx);
			ly = pick_coord(ly);
			send_beat(ACT_LOAD, i, lx, ly);
		end
	endtask

	task automatic pick_point(output int px, output int py);
		int a, r;
		r = (live_n == 0) ? 0 : int'($urandom_range(9));
		a = (live_n == 0) ? 0 : int'($urandom_range(live_n - 1));
		px = int'($urandom_range(65535)) - 32768;
		py = int'($urandom_range(65535)) - 32768;
		case (r)
			1: begin
				px = int'($urandom_range(16)) - 8;
				py = int'($urandom_range(16)) - 8;
			end
			2: begin
				px = vx[a];
				py = vy[a];
			end
			3: begin
				px = clip16(vx[a] + int'($urandom_range(200)) - 100);
				py = vy[a];
			end
			4: begin
				px = (vx[a] + vx[(a + 1) % live_n]) / 2;
				py = (vy[a] + vy[(a + 1) % live_n]) / 2;
			end
			5: begin
				px = clip16(vx[a] + int'($urandom_range(2)) - 1);
				py = clip16(vy[a] + int'($urandom_range(2)) - 1);
			end
			6: begin
				px = rail_coord();
				py = rail_coord();
			end
			7: begin
				px = vx[a];
				py = vy[$urandom_range(live_n - 1)];
			end
			8: py = vy[a];
			default: ;
		endcase
	endtask

	task automatic settle();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_count(input int val);
		cfg_data = CNT_W'(val);
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int px, py, phase_end, r;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extreme triangle, horizontal base on the lowest row
		send_beat(ACT_LOAD, 0, -32768, -32768);
		send_beat(ACT_LOAD, 1, 32767, -32768);
		send_beat(ACT_LOAD, 2, 0, 32767);
		send_beat(ACT_TEST, 0, 0, 0);
		send_beat(ACT_TEST, 0, -32768, -32768);
		send_beat(ACT_TEST, 0, 32767, 32767);
		send_beat(ACT_TEST, 0, -32768, 32767);
		send_beat(ACT_TEST, 0, 0, -32768);
		send_beat(ACT_TEST, 0, 0, 32767);
		send_beat(ACT_TEST, 0, 32767, -32767);
		// right triangle: vertical leg, horizontal leg, slanted hypotenuse
		send_beat(ACT_LOAD, 0, 0, 0);
		send_beat(ACT_LOAD, 1, 0, 100);
		send_beat(ACT_LOAD, 2, 100, 0);
		send_beat(ACT_TEST, 0, 0, 50);
		send_beat(ACT_TEST, 0, 50, 0);
		send_beat(ACT_TEST, 0, 50, 50);
		send_beat(ACT_TEST, 0, 10, 10);
		send_beat(ACT_TEST, 0, -1, 50);
		send_beat(ACT_TEST, 0, 0, 100);
		send_beat(ACT_TEST, 0, 51, 50);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			write_count(phase_counts[p]);
			live_n = (phase_counts[p] > MAX_VERTICES) ? MAX_VERTICES : phase_counts[p];
			phase_end = beats + BEATS_PER_PHASE;
			load_polygon(live_n);
			while (beats < phase_end) begin
				r = $urandom_range(99);
				if (r < 75) begin
					pick_point(px, py);
					send_beat(ACT_TEST, $urandom_range(MAX_VERTICES - 1), px, py);
				end else if (r < 92) begin
					send_beat(ACT_LOAD, $urandom_range(MAX_VERTICES - 1),
						pick_coord(0), pick_coord(0));
				end else begin
					load_polygon(live_n);
				end
			end
		end

		settle();
		if (fails == 0 && pending == 0)
			$display("point_in_polygon_test_core: match");
		else
			$display("point_in_polygon_test_core: mismatch");
		$finish;
	end

endmodule
